// File: rtl/pn_pkg.sv
// Shared types, constants and helpers of the peak normalizer.
// No dependencies; compiled first.
`default_nettype none

package pn_pkg;

	// 1.0 in Q0.15 as used by the scale pass
	localparam logic [14:0] FULL_SCALE = 15'h7FFF;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned PEAK_W   = 15;
	localparam int unsigned PROD_W   = SAMPLE_W + PEAK_W;
	// quotient bits produced after the overflow check
	localparam int unsigned QUOT_W   = PEAK_W;

	localparam logic REQ_MEASURE = 1'b0;
	localparam logic REQ_SCALE   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} pn_state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
		logic sat;
	} div_stat_t;

	// magnitude of a two's complement sample, 0..32768
	function automatic logic [SAMPLE_W-1:0] abs_mag(input logic signed [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] u;
		u = s;
		abs_mag = s[SAMPLE_W-1] ? (~u + 1'b1) : u;
	endfunction

endpackage

`default_nettype wire

// File: rtl/pn_req_if.sv
// Request channel of the peak normalizer: valid/ready plus request fields.
// No dependencies.
`default_nettype none

interface pn_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [15:0] sample;
	logic               first_of_buffer;

	modport source (output valid, output req_type, output sample, output first_of_buffer,
		input ready);
	modport sink (input valid, input req_type, input sample, input first_of_buffer,
		output ready);
endinterface

`default_nettype wire

// File: rtl/pn_rsp_if.sv
// Response channel of the peak normalizer: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface pn_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] scaled;
	logic               zero_peak;

	modport source (output valid, output scaled, output zero_peak, input ready);
	modport sink (input valid, input scaled, input zero_peak, output ready);
endinterface

`default_nettype wire

// File: rtl/peak_normalizer.sv
// Peak normalizer top level: sequencer, multiplier and output register.
// Depends on pn_pkg, pn_req_if, pn_rsp_if, pn_peak and pn_divider.
//
// Usage:
//   req carries transactions of req_type, sample and first_of_buffer.
//   A measure transaction (req_type 0) updates the held peak in the cycle
//   it is accepted and gives no response; first_of_buffer restarts the peak.
//   A scale transaction (req_type 1) gives one response on rsp: scaled is
//   trunc(sample * 32767 / peak), saturated to +/-32767, and zero_peak marks
//   a held peak of zero (scaled is then 0).
//   Sequence: a measure is taken whenever req is ready. A scale runs the multiply
//   in ST_MUL, then the shared compare/subtract unit runs an overflow check plus 15
//   restoring steps in ST_DIV; ST_OUT loads the output register, and the response
//   becomes valid as the sequencer returns to ST_IDLE and req is ready again. A
//   saturating quotient ends after the check; a zero peak goes from ST_IDLE
//   straight to ST_OUT and skips the multiply and the divide.
//   req.ready is low while a scale transaction is in flight. The response
//   sits in an output register; if rsp stalls, the finished result waits in
//   the sequencer until the register frees.
//   Reset clears the held peak to zero and empties the output register.
`default_nettype none

module peak_normalizer (
	input wire logic clk,
	input wire logic arst_n,
	pn_req_if.sink   req,
	pn_rsp_if.source rsp
);
	import pn_pkg::*;

	pn_state_t state_q, state_d;

	logic                       acc;
	logic                       meas;
	logic [PEAK_W-1:0]          peak;
	logic [SAMPLE_W-1:0]        mag_q;
	logic                       neg_q;
	logic                       zp_q;
	logic [PROD_W-1:0]          prod;
	div_ctrl_t                  div_ctrl;
	div_stat_t                  div_stat;
	logic [QUOT_W-1:0]          quot;
	logic [SAMPLE_W-1:0]        qmag;
	logic [SAMPLE_W-1:0]        result;
	logic                       out_free;
	logic                       out_load;
	logic                       req_ready;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] scaled_q;
	logic                       zero_peak_q;

	assign acc      = req.valid && req_ready;
	assign meas     = acc && (req.req_type == REQ_MEASURE);
	assign out_free = !out_valid_q || rsp.ready;

	pn_peak u_peak (
		.clk             (clk),
		.arst_n          (arst_n),
		.meas            (meas),
		.sample          (req.sample),
		.first_of_buffer (req.first_of_buffer),
		.peak            (peak)
	);

	assign prod = PROD_W'(mag_q) * PROD_W'(FULL_SCALE);

	pn_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (prod),
		.divisor  (peak),
		.stat     (div_stat),
		.quot     (quot)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid && req.req_type == REQ_SCALE) begin
					state_d = (peak == '0) ? ST_OUT : ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready      = 1'b0;
		div_ctrl.start = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			ST_IDLE: req_ready      = 1'b1;
			ST_MUL:  div_ctrl.start = 1'b1;
			ST_DIV:  ;
			ST_OUT:  out_load       = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the scale operand; measure transactions leave it alone
	always_ff @(posedge clk) begin
		if (acc && req.req_type == REQ_SCALE) begin
			mag_q <= abs_mag(req.sample);
			neg_q <= req.sample[SAMPLE_W-1];
			zp_q  <= (peak == '0);
		end
	end

	assign qmag   = div_stat.sat ? {1'b0, FULL_SCALE} : {1'b0, quot};
	assign result = zp_q ? '0 : (neg_q ? (~qmag + 1'b1) : qmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			scaled_q    <= result;
			zero_peak_q <= zp_q;
		end
	end

	assign req.ready     = req_ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.scaled    = scaled_q;
	assign rsp.zero_peak = zero_peak_q;

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_peak_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!meas |=> $stable(peak))
		else $error("peak changed without a measure transaction");

	a_zero_peak_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.zero_peak |-> rsp.scaled == '0)
		else $error("zero peak response with nonzero output");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.scaled != {1'b1, {(SAMPLE_W-1){1'b0}}})
		else $error("scaled output out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/pn_peak.sv
// Held peak magnitude, updated by measure transactions.
// Depends on pn_pkg.
`default_nettype none

module pn_peak (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            meas,
	input  wire logic signed [pn_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                            first_of_buffer,
	output logic         [pn_pkg::PEAK_W-1:0]   peak
);
	import pn_pkg::*;

	logic [SAMPLE_W-1:0] mag;
	logic [PEAK_W-1:0]   mag_sat;
	logic [PEAK_W-1:0]   peak_q;

	assign mag = abs_mag(sample);
	// most negative sample saturates to full scale
	assign mag_sat = mag[SAMPLE_W-1] ? FULL_SCALE : mag[PEAK_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (meas && (first_of_buffer || mag_sat > peak_q)) begin
			peak_q <= mag_sat;
		end
	end

	assign peak = peak_q;
endmodule

`default_nettype wire

// File: rtl/pn_divider.sv
// Restoring divider with one shared compare/subtract unit, one step a cycle.
// Depends on pn_pkg.
`default_nettype none

module pn_divider (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pn_pkg::div_ctrl_t              ctrl,
	input  wire logic [pn_pkg::PROD_W-1:0]      dividend,
	input  wire logic [pn_pkg::PEAK_W-1:0]      divisor,
	output pn_pkg::div_stat_t                   stat,
	output logic      [pn_pkg::QUOT_W-1:0]      quot
);
	import pn_pkg::*;

	localparam int unsigned REM_W = PEAK_W + 1;
	localparam int unsigned CNT_W = $clog2(QUOT_W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W);

	logic [REM_W-1:0]  rem_q;
	logic [QUOT_W-1:0] dvd_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              sat_q;

	logic [REM_W-1:0]  cur;
	logic [REM_W:0]    diff;
	logic              ge;
	logic              check;

	// step zero compares the high part alone: quotient would not fit
	assign check = (cnt_q == '0);
	assign cur   = check ? rem_q : {rem_q[REM_W-2:0], dvd_q[QUOT_W-1]};
	assign diff  = {1'b0, cur} - {2'b00, divisor};
	assign ge    = !diff[REM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sat_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				sat_q  <= 1'b0;
			end else if (busy_q) begin
				if (check && ge) begin
					sat_q  <= 1'b1;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q  <= dividend[PROD_W-1:QUOT_W];
			dvd_q  <= dividend[QUOT_W-1:0];
			quot_q <= '0;
		end else if (busy_q && !check) begin
			rem_q  <= ge ? diff[REM_W-1:0] : cur;
			dvd_q  <= {dvd_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	// the final step of a non-saturated division runs at cnt_q == LAST_STEP
	assign stat.done = done_q;
	assign stat.sat  = sat_q;
	assign quot      = quot_q;
endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for peak_normalizer: directed and random traffic with a
// built-in peak tracker and divider predictor. Depends on pn_pkg, pn_req_if, pn_rsp_if, peak_normalizer.

module tb_top;
	import pn_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 40;

	typedef struct packed {
		logic signed [15:0] scaled;
		logic               zero_peak;
	} norm_result_t;

	logic clk;
	logic arst_n;

	pn_req_if req_ch ();
	pn_rsp_if rsp_ch ();

	peak_normalizer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// predictor state and pending results
	logic [14:0]  held_peak;
	norm_result_t scaled_q[$];

	int src_idle_pct;
	int snk_stall_pct;
	int hold_reqs;
	int err_count;
	int cycle_count;
	int n_measures;
	int n_scales;
	int n_results;
	int n_zero;
	int n_sat;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("peak_normalizer regression: fail");
			$finish;
		end
	end

	function automatic norm_result_t normalize(logic signed [15:0] s, logic [14:0] pk);
		norm_result_t r;
		int           sv;
		int           mag;
		int           q;
		sv  = s;
		mag = (sv < 0) ? -sv : sv;
		r.zero_peak = (pk == '0);
		if (r.zero_peak) begin
			r.scaled = '0;
		end else begin
			q = (mag * int'(FULL_SCALE)) / int'(pk);
			if (q > int'(FULL_SCALE))
				q = int'(FULL_SCALE);
			r.scaled = 16'((sv < 0) ? -q : q);
		end
		return r;
	endfunction

	function automatic logic [14:0] track_peak(logic signed [15:0] s, logic first,
		logic [14:0] pk);
		int sv;
		int mag;
		sv  = s;
		mag = (sv < 0) ? -sv : sv;
		if (mag > int'(FULL_SCALE))
			mag = int'(FULL_SCALE);
		if (first || mag > int'(pk))
			return 15'(mag);
		return pk;
	endfunction

	function automatic logic signed [15:0] bounded_sample(int amp);
		int v;
		v = int'($urandom_range(2 * amp)) - amp;
		if (v > 32767)
			v = 32767;
		return 16'(v);
	endfunction

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return bounded_sample(16);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_amplitude();
		case ($urandom_range(3))
			0: return int'($urandom_range(1, 16));
			1: return int'($urandom_range(17, 1024));
			2: return int'($urandom_range(1025, 32767));
			default: return 32768;
		endcase
	endfunction

	// idle at random, present one transaction and wait for it to be taken
	task automatic send_req(logic rt, logic signed [15:0] s, logic first);
		while (int'($urandom_range(99)) < src_idle_pct) begin
			@(negedge clk);
			req_ch.valid           <= 1'b0;
			req_ch.req_type        <= 1'($urandom);
			req_ch.sample          <= 16'($urandom);
			req_ch.first_of_buffer <= 1'($urandom);
		end
		@(negedge clk);
		req_ch.valid           <= 1'b1;
		req_ch.req_type        <= rt;
		req_ch.sample          <= s;
		req_ch.first_of_buffer <= first;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (rt == REQ_MEASURE) begin
			held_peak = track_peak(s, first, held_peak);
			n_measures++;
		end else begin
			scaled_q.push_back(normalize(s, held_peak));
			n_scales++;
		end
	endtask

	// drop valid and hold until every pending result has come back
	task automatic settle_outputs();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (scaled_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin : rsp_ready_drive
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= (int'($urandom_range(99)) >= snk_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		norm_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (scaled_q.size() == 0) begin
				$error("unexpected transaction: scaled %0d zero_peak %0b",
					rsp_ch.scaled, rsp_ch.zero_peak);
				err_count++;
			end else begin
				want = scaled_q.pop_front();
				n_results++;
				if (want.zero_peak)
					n_zero++;
				if (want.scaled == 16'sd32767 || want.scaled == -16'sd32767)
					n_sat++;
				if (rsp_ch.scaled !== want.scaled) begin
					$error("scaled: expected %0d, got %0d", want.scaled, rsp_ch.scaled);
					err_count++;
				end
				if (rsp_ch.zero_peak !== want.zero_peak) begin
					$error("zero_peak: expected %0b, got %0b", want.zero_peak,
						rsp_ch.zero_peak);
					err_count++;
				end
			end
		end
	end

	// peak is zero out of reset, then restarted to zero by a measure
	task automatic test_zero_peak();
		send_req(REQ_SCALE, 16'sd0, 1'b0);
		send_req(REQ_SCALE, 16'sh8000, 1'b0);
		send_req(REQ_SCALE, 16'sd32767, 1'b1);
		send_req(REQ_MEASURE, 16'sd0, 1'b1);
		send_req(REQ_SCALE, 16'sd123, 1'b0);
		settle_outputs();
	endtask

	// most negative sample saturates the peak magnitude to full scale
	task automatic test_full_scale();
		send_req(REQ_MEASURE, 16'sh8000, 1'b1);
		send_req(REQ_SCALE, 16'sh8000, 1'b0);
		send_req(REQ_SCALE, 16'sd32767, 1'b0);
		send_req(REQ_SCALE, -16'sd1, 1'b0);
		send_req(REQ_SCALE, 16'sd16384, 1'b0);
		settle_outputs();
	endtask

	// samples above a tiny peak saturate with their sign kept
	task automatic test_saturation();
		send_req(REQ_MEASURE, 16'sd1, 1'b1);
		send_req(REQ_SCALE, 16'sd1, 1'b0);
		send_req(REQ_SCALE, 16'sd2, 1'b0);
		send_req(REQ_SCALE, -16'sd2, 1'b0);
		send_req(REQ_SCALE, 16'sh8000, 1'b0);
		send_req(REQ_SCALE, 16'sd0, 1'b0);
		settle_outputs();
	endtask

	// peak only grows until restarted; first flag has no effect on scale
	task automatic test_peak_tracking();
		send_req(REQ_MEASURE, 16'sd100, 1'b1);
		send_req(REQ_MEASURE, 16'sd50, 1'b0);
		send_req(REQ_MEASURE, -16'sd300, 1'b0);
		send_req(REQ_MEASURE, 16'sd200, 1'b0);
		send_req(REQ_SCALE, 16'sd150, 1'b0);
		send_req(REQ_SCALE, -16'sd300, 1'b1);
		send_req(REQ_MEASURE, 16'sd7, 1'b1);
		send_req(REQ_SCALE, 16'sd3, 1'b0);
		settle_outputs();
	endtask

	// stall the receiver long enough that the request side backs up
	task automatic test_backpressure();
		int k;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		send_req(REQ_MEASURE, bounded_sample(20000), 1'b1);
		hold_reqs++;
		for (k = 0; k < 8; k++)
			send_req(REQ_SCALE, rand_sample(), 1'($urandom));
		settle_outputs();
	endtask

	// mostly measure-then-scale buffers with random content, some loose noise
	task automatic test_random_buffers(int src_pct, int snk_pct, int n_items);
		int                 sent;
		int                 amp;
		int                 n_meas;
		int                 n_scl;
		int                 k;
		logic signed [15:0] s;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) < 8) begin
				amp    = pick_amplitude();
				n_meas = int'($urandom_range(1, 8));
				n_scl  = int'($urandom_range(1, 8));
				for (k = 0; k < n_meas; k++)
					send_req(REQ_MEASURE, bounded_sample(amp), k == 0);
				for (k = 0; k < n_scl; k++) begin
					case ($urandom_range(7))
						0: s = 16'({1'b0, held_peak});
						1: s = 16'(-int'(held_peak));
						2: s = rand_sample();
						default: s = bounded_sample(amp);
					endcase
					send_req(REQ_SCALE, s, 1'($urandom));
				end
				sent += n_meas + n_scl;
			end else begin
				send_req(1'($urandom), rand_sample(), 1'($urandom));
				sent++;
			end
		end
		settle_outputs();
	endtask

	initial begin
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.req_type        = REQ_MEASURE;
		req_ch.sample          = '0;
		req_ch.first_of_buffer = 1'b0;
		held_peak     = '0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_reqs     = 0;
		err_count     = 0;
		cycle_count   = 0;
		n_measures    = 0;
		n_scales      = 0;
		n_results     = 0;
		n_zero        = 0;
		n_sat         = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zero_peak();
		test_full_scale();
		test_saturation();
		test_peak_tracking();
		test_backpressure();
		test_random_buffers(0, 0, 150);
		test_random_buffers(75, 0, 150);
		test_random_buffers(0, 75, 150);
		test_random_buffers(8, 8, 150);
		settle_outputs();

		$display("covered %0d measure and %0d scale requests; %0d results checked",
			n_measures, n_scales, n_results);
		$display("  incl. %0d on a zero peak and %0d at full scale, idle and stall mixes",
			n_zero, n_sat);
		if (err_count == 0) begin
			$display("peak_normalizer regression: pass");
		end else begin
			$display("peak_normalizer regression: fail");
		end
		$finish;
	end

endmodule
